// ----- rtl/segment_intersection_defines.svh -----
// ---------------------------------------------------------------------------
// segment_intersection_defines
// assertion macros for the segment intersection rtl top level
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH
`ifndef SYNTH
// checked only while reset is released
`define SEGI_ASSERT(lbl, clock, rstn, prop) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error("segment_intersection assertion failed");
// checked at every edge, reset included
`define SEGI_ASSERT_ALWAYS(lbl, clock, prop) \
	lbl: assert property (@(posedge clock) prop) \
		else $error("segment_intersection assertion failed");
`else
`define SEGI_ASSERT(lbl, clock, rstn, prop)
`define SEGI_ASSERT_ALWAYS(lbl, clock, prop)
`endif
`endif

// ----- rtl/segi_pkg.sv -----
// ---------------------------------------------------------------------------
// segi_pkg
// widths, payload types and the divider step for segment intersection
// ---------------------------------------------------------------------------
`default_nettype none
package segi_pkg;
	localparam int CW = 16;           // coordinate width
	localparam int DW = CW + 1;       // coordinate difference
	localparam int PW = 2 * DW;       // difference product
	localparam int XW = PW + 1;       // denominator and numerators
	localparam int NW = CW + XW + 2;  // cramer numerator

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic hit;
		logic col;
	} flags_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [CW-1:0] quo;
		logic          neg;
	} lane_t;

	// one restoring division step for quotient bit pos
	function automatic lane_t div_step(lane_t l, logic [XW-1:0] dvs, int pos);
		logic [NW-1:0] sh;
		logic [NW:0]   diff;
		lane_t         r;
		sh   = NW'(dvs) << pos;
		diff = {1'b0, l.rem} - {1'b0, sh};
		r    = l;
		if (!diff[NW]) begin
			r.rem      = diff[NW-1:0];
			r.quo[pos] = 1'b1;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/segment_intersection.sv -----
// pipeline: an accepted input beat passes through to its result beat
// (6 front-end stages, 16 divider stages, 1 output register)
// throughput: one beat per cycle; the whole pipe advances together,
// held only while a result waits under result_stall
// reset: arst_n clears the valid bits only, payload registers are not reset
// ---------------------------------------------------------------------------
// segment_intersection
// tests two segments for a crossing and gives the crossing point
// ---------------------------------------------------------------------------
`default_nettype none
`include "segment_intersection_defines.svh"
module segment_intersection (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire segi_pkg::coord_t  first_start_x,
	input  wire segi_pkg::coord_t  first_start_y,
	input  wire segi_pkg::coord_t  first_end_x,
	input  wire segi_pkg::coord_t  first_end_y,
	input  wire segi_pkg::coord_t  second_start_x,
	input  wire segi_pkg::coord_t  second_start_y,
	input  wire segi_pkg::coord_t  second_end_x,
	input  wire segi_pkg::coord_t  second_end_y,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic                   hit,
	output logic                   collinear,
	output segi_pkg::coord_t       point_x,
	output segi_pkg::coord_t       point_y
);
	logic                        en;
	logic                        fv, dv;
	segi_pkg::flags_t            ff, df;
	segi_pkg::lane_t             flx, fly, dlx, dly;
	logic [segi_pkg::XW-1:0]     fdvs;

	logic                        valid_q;
	logic                        hit_q, col_q;
	segi_pkg::coord_t            px_q, py_q;

	// advance unless a result beat is being held
	assign en         = !valid_q || !result_stall;
	assign item_stall = !en;

	segi_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vin   (item_valid),
		.ax    (first_start_x),
		.ay    (first_start_y),
		.bx    (first_end_x),
		.by    (first_end_y),
		.cx    (second_start_x),
		.cy    (second_start_y),
		.dx    (second_end_x),
		.dy    (second_end_y),
		.vout  (fv),
		.flags (ff),
		.lx    (flx),
		.ly    (fly),
		.dvs   (fdvs)
	);

	segi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vin   (fv),
		.fin   (ff),
		.lxin  (flx),
		.lyin  (fly),
		.dvsin (fdvs),
		.vout  (dv),
		.fout  (df),
		.lxout (dlx),
		.lyout (dly)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= df.hit;
			col_q <= df.col;
			if (df.hit) begin
				px_q <= dlx.neg ? -dlx.quo : dlx.quo;
				py_q <= dly.neg ? -dly.quo : dly.quo;
			end else begin
				px_q <= '0;
				py_q <= '0;
			end
		end
	end

	assign result_valid = valid_q;
	assign hit          = hit_q;
	assign collinear    = col_q;
	assign point_x      = px_q;
	assign point_y      = py_q;

	`SEGI_ASSERT(a_flags_excl, clk, arst_n, result_valid |-> !(hit && collinear))
	`SEGI_ASSERT(a_zero_miss, clk, arst_n, (result_valid && !hit) |-> (point_x == '0 && point_y == '0))
	`SEGI_ASSERT(a_stall_link, clk, arst_n, item_stall == (result_valid && result_stall))
endmodule
`default_nettype wire

// ----- rtl/segi_front.sv -----
// ---------------------------------------------------------------------------
// segi_front
// six-stage front end: cross products, range tests, cramer numerators
// ---------------------------------------------------------------------------
`default_nettype none
module segi_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     vin,
	input  wire segi_pkg::coord_t         ax,
	input  wire segi_pkg::coord_t         ay,
	input  wire segi_pkg::coord_t         bx,
	input  wire segi_pkg::coord_t         by,
	input  wire segi_pkg::coord_t         cx,
	input  wire segi_pkg::coord_t         cy,
	input  wire segi_pkg::coord_t         dx,
	input  wire segi_pkg::coord_t         dy,
	output logic                          vout,
	output segi_pkg::flags_t              flags,
	output segi_pkg::lane_t               lx,
	output segi_pkg::lane_t               ly,
	output logic [segi_pkg::XW-1:0]       dvs
);
	localparam int DW = segi_pkg::DW;
	localparam int PW = segi_pkg::PW;
	localparam int XW = segi_pkg::XW;
	localparam int NW = segi_pkg::NW;
	localparam int CW = segi_pkg::CW;

	logic [6:1] v_q;

	logic signed [DW-1:0] abx_s1, aby_s1, cdx_s1, cdy_s1, acx_s1, acy_s1;
	segi_pkg::coord_t     ax_s1, ay_s1;

	logic signed [PW-1:0] pda_s2, pdb_s2, p1a_s2, p1b_s2, p2a_s2, p2b_s2;
	logic signed [DW-1:0] abx_s2, aby_s2;
	segi_pkg::coord_t     ax_s2, ay_s2;

	logic signed [XW-1:0] den_s3, num1_s3, num2_s3;
	logic signed [DW-1:0] abx_s3, aby_s3;
	segi_pkg::coord_t     ax_s3, ay_s3;

	logic signed [CW+XW-1:0] mxa_s4, mya_s4;
	logic signed [XW+DW-1:0] mxb_s4, myb_s4;
	logic [XW-1:0]           dmag_s4;
	logic                    dneg_s4;
	segi_pkg::flags_t        fl_s4;

	logic signed [NW-1:0] nx_s5, ny_s5;
	logic [XW-1:0]        dmag_s5;
	logic                 dneg_s5;
	segi_pkg::flags_t     fl_s5;

	segi_pkg::lane_t  lx_s6, ly_s6;
	logic [XW-1:0]    dmag_s6;
	segi_pkg::flags_t fl_s6;

	// range test on the sign-normalised numerators
	logic                 dneg;
	logic signed [XW:0]   dm, n1a, n2a;
	segi_pkg::flags_t     fl_nx;

	always_comb begin
		dneg = den_s3[XW-1];
		dm   = dneg ? -(XW+1)'(den_s3)  : (XW+1)'(den_s3);
		n1a  = dneg ? -(XW+1)'(num1_s3) : (XW+1)'(num1_s3);
		n2a  = dneg ? -(XW+1)'(num2_s3) : (XW+1)'(num2_s3);
		fl_nx.col = (den_s3 == '0) && (num1_s3 == '0) && (num2_s3 == '0);
		fl_nx.hit = (den_s3 != '0) && !n1a[XW] && (n1a <= dm)
			&& !n2a[XW] && (n2a <= dm);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:1], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abx_s1 <= DW'(bx) - DW'(ax);
			aby_s1 <= DW'(by) - DW'(ay);
			cdx_s1 <= DW'(dx) - DW'(cx);
			cdy_s1 <= DW'(dy) - DW'(cy);
			acx_s1 <= DW'(ax) - DW'(cx);
			acy_s1 <= DW'(ay) - DW'(cy);
			ax_s1  <= ax;
			ay_s1  <= ay;

			pda_s2 <= abx_s1 * cdy_s1;
			pdb_s2 <= aby_s1 * cdx_s1;
			p1a_s2 <= acy_s1 * cdx_s1;
			p1b_s2 <= acx_s1 * cdy_s1;
			p2a_s2 <= acy_s1 * abx_s1;
			p2b_s2 <= acx_s1 * aby_s1;
			abx_s2 <= abx_s1;
			aby_s2 <= aby_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;

			den_s3  <= XW'(pda_s2) - XW'(pdb_s2);
			num1_s3 <= XW'(p1a_s2) - XW'(p1b_s2);
			num2_s3 <= XW'(p2a_s2) - XW'(p2b_s2);
			abx_s3  <= abx_s2;
			aby_s3  <= aby_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;

			mxa_s4  <= ax_s3 * den_s3;
			mya_s4  <= ay_s3 * den_s3;
			mxb_s4  <= num1_s3 * abx_s3;
			myb_s4  <= num1_s3 * aby_s3;
			dmag_s4 <= dm[XW-1:0];
			dneg_s4 <= dneg;
			fl_s4   <= fl_nx;

			nx_s5   <= NW'(mxa_s4) + NW'(mxb_s4);
			ny_s5   <= NW'(mya_s4) + NW'(myb_s4);
			dmag_s5 <= dmag_s4;
			dneg_s5 <= dneg_s4;
			fl_s5   <= fl_s4;

			lx_s6.rem <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			lx_s6.quo <= '0;
			lx_s6.neg <= nx_s5[NW-1] ^ dneg_s5;
			ly_s6.rem <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
			ly_s6.quo <= '0;
			ly_s6.neg <= ny_s5[NW-1] ^ dneg_s5;
			dmag_s6   <= dmag_s5;
			fl_s6     <= fl_s5;
		end
	end

	assign vout  = v_q[6];
	assign flags = fl_s6;
	assign lx    = lx_s6;
	assign ly    = ly_s6;
	assign dvs   = dmag_s6;
endmodule
`default_nettype wire

// ----- rtl/segi_div.sv -----
// ---------------------------------------------------------------------------
// segi_div
// pipelined restoring divider, one quotient bit per stage, x and y lanes
// ---------------------------------------------------------------------------
`default_nettype none
module segi_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     vin,
	input  wire segi_pkg::flags_t         fin,
	input  wire segi_pkg::lane_t          lxin,
	input  wire segi_pkg::lane_t          lyin,
	input  wire logic [segi_pkg::XW-1:0]  dvsin,
	output logic                          vout,
	output segi_pkg::flags_t              fout,
	output segi_pkg::lane_t               lxout,
	output segi_pkg::lane_t               lyout
);
	localparam int CW = segi_pkg::CW;
	localparam int XW = segi_pkg::XW;

	logic              v_q   [1:CW];
	segi_pkg::flags_t  f_q   [1:CW];
	segi_pkg::lane_t   lx_q  [1:CW];
	segi_pkg::lane_t   ly_q  [1:CW];
	logic [XW-1:0]     dv_q  [1:CW];

	segi_pkg::flags_t  f_in  [0:CW-1];
	segi_pkg::lane_t   lx_in [0:CW-1];
	segi_pkg::lane_t   ly_in [0:CW-1];
	logic [XW-1:0]     dv_in [0:CW-1];
	logic              v_in  [0:CW-1];

	assign v_in[0]  = vin;
	assign f_in[0]  = fin;
	assign lx_in[0] = lxin;
	assign ly_in[0] = lyin;
	assign dv_in[0] = dvsin;

	for (genvar k = 0; k < CW; k++) begin : g_stage
		if (k > 0) begin : g_link
			assign v_in[k]  = v_q[k];
			assign f_in[k]  = f_q[k];
			assign lx_in[k] = lx_q[k];
			assign ly_in[k] = ly_q[k];
			assign dv_in[k] = dv_q[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_in[k];
			end
		end

		// msb of the quotient first
		always_ff @(posedge clk) begin
			if (en) begin
				lx_q[k+1] <= segi_pkg::div_step(lx_in[k], dv_in[k], CW-1-k);
				ly_q[k+1] <= segi_pkg::div_step(ly_in[k], dv_in[k], CW-1-k);
				dv_q[k+1] <= dv_in[k];
				f_q[k+1]  <= f_in[k];
			end
		end
	end

	assign vout  = v_q[CW];
	assign fout  = f_q[CW];
	assign lxout = lx_q[CW];
	assign lyout = ly_q[CW];
endmodule
`default_nettype wire
